// ----- hw/rtl/pmst_pkg.sv -----
// ----------------------------------------------------------------------------
// Minimum spanning tree package
// Shared constants and request/response types for the spanning tree unit.
// ----------------------------------------------------------------------------
package pmst_pkg;

   localparam int MaxVertices = 64;
   localparam int WeightBits  = 16;
   localparam int VertexBits  = $clog2(MaxVertices);
   localparam int CountBits   = 7;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_RUN   = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [5:0]  row_vertex;
      logic [5:0]  column_vertex;
      logic [15:0] entry_weight;
   } req_type;

   typedef struct packed {
      logic [5:0]  edge_from;
      logic [5:0]  edge_to;
      logic [15:0] edge_cost;
      logic        last_edge;
   } rsp_type;

endpackage

// ----- hw/rtl/prim_minimum_spanning_tree_unit.sv -----
// ----------------------------------------------------------------------------
// Prim minimum spanning tree unit
// Loads a cost matrix and emits the edges of a minimum spanning tree.
// ----------------------------------------------------------------------------
// A write request stores one cost entry. A run request walks the cost
// memory, which has one registered read port: the first-edge scan reads
// about N*N/2 entries and the nearest-link setup 2N. Each of the N-2 later
// steps runs a search over all N vertices, followed by an update in every
// step but the last. Tree vertices are skipped; for any other vertex the
// registered nearest-link memory is read before the link cost is used.
// One request is handled at a time. Edges are held in an output register,
// and the unit waits before emitting a new edge while the previous one is
// still waiting to be taken.
module prim_minimum_spanning_tree_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pmst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pmst_pkg::rsp_type rsp_payload,
   input  logic              csr_write,
   input  logic [6:0]        csr_data
);

   localparam int VB = pmst_pkg::VertexBits;
   localparam int WB = pmst_pkg::WeightBits;
   localparam int CB = pmst_pkg::CountBits;

   // State codes.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCAN  = 4'd1;  // first edge search
   localparam logic [3:0] ST_FEMIT = 4'd2;  // emit first edge
   localparam logic [3:0] ST_INIT  = 4'd3;  // nearest link setup
   localparam logic [3:0] ST_SRCH  = 4'd4;  // nearest non-tree vertex
   localparam logic [3:0] ST_SEMIT = 4'd5;
   localparam logic [3:0] ST_UPD   = 4'd6;  // nearest link update
   localparam logic [3:0] ST_FIN   = 4'd8;

   // Memories.
   logic [WB-1:0] cost_mem [pmst_pkg::MaxVertices*pmst_pkg::MaxVertices];
   logic [VB-1:0] near_mem [pmst_pkg::MaxVertices];
   logic [pmst_pkg::MaxVertices-1:0] tree_ff, tree_in;

   logic [CB-1:0] count_ff;
   logic [VB-1:0] n_last;           // highest vertex in use
   logic [3:0]    state_ff, state_in;
   logic [VB-1:0] i_ff, i_in, j_ff, j_in;
   logic          ph_ff, ph_in;     // two-read phase within a vertex
   logic          pend_ff, pend_in; // a read issued last cycle
   logic [VB-1:0] pi_ff, pi_in;     // vertex of that read
   logic [VB-1:0] pj_ff, pj_in;
   logic [VB-1:0] pn_ff, pn_in;     // nearest link used by that read
   logic          pph_ff, pph_in;
   logic [WB-1:0] best_ff, best_in, tmp_ff, tmp_in;
   logic          found_ff, found_in;
   logic [VB-1:0] k_ff, k_in, l_ff, l_in, u_ff, u_in;
   logic [VB-1:0] un_ff, un_in;     // nearest tree vertex of u
   logic [VB-1:0] step_ff, step_in;
   logic          done_ff, done_in;
   logic          rv_ff, rv_in;
   pmst_pkg::rsp_type rsp_ff, rsp_in;

   logic            rd_en;
   logic [2*VB-1:0] rd_addr;
   logic [WB-1:0]   rd_data;
   logic            nw_en;
   logic [VB-1:0]   nw_addr, nw_data, near_q;
   logic            cw_en;

   // Saturated vertex count, as highest index.
   always_comb begin
      if (count_ff < CB'(2)) begin
         n_last = VB'(1);
      end else if (count_ff > CB'(pmst_pkg::MaxVertices)) begin
         n_last = VB'(pmst_pkg::MaxVertices - 1);
      end else begin
         n_last = VB'(count_ff - CB'(1));
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CB'(pmst_pkg::MaxVertices);
      end else if (csr_write) begin
         count_ff <= csr_data;
      end
   end

   // Cost memory, one write and one registered read per cycle.
   assign cw_en = req_valid && req_ready && req_payload.operation == pmst_pkg::OP_WRITE;
   always_ff @(posedge clock) begin
      if (cw_en) begin
         cost_mem[{req_payload.row_vertex, req_payload.column_vertex}] <=
            req_payload.entry_weight;
      end
      if (rd_en) begin
         rd_data <= cost_mem[rd_addr];
      end
   end

   // Nearest-link memory, read every cycle at the current vertex.
   always_ff @(posedge clock) begin
      if (nw_en) begin
         near_mem[nw_addr] <= nw_data;
      end
      near_q <= near_mem[i_ff];
   end

   assign req_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = rv_ff;
   assign rsp_payload = rsp_ff;

   // Sequencer: issue at most one read per cycle, consume its data in the next cycle.
   always_comb begin
      state_in = state_ff;  i_in = i_ff;  j_in = j_ff;  ph_in = ph_ff;
      pend_in = 1'b0;  pi_in = i_ff;  pj_in = j_ff;  pph_in = ph_ff;
      pn_in = pn_ff;  un_in = un_ff;
      best_in = best_ff;  tmp_in = tmp_ff;  found_in = found_ff;
      k_in = k_ff;  l_in = l_ff;  u_in = u_ff;  step_in = step_ff;
      done_in = done_ff;  tree_in = tree_ff;
      rv_in = rv_ff;  rsp_in = rsp_ff;
      rd_en = 1'b0;  rd_addr = '0;
      nw_en = 1'b0;  nw_addr = '0;  nw_data = '0;
      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_payload.operation == pmst_pkg::OP_RUN) begin
               state_in = ST_SCAN;  i_in = '0;  j_in = VB'(1);
               k_in = '0;  l_in = VB'(1);  found_in = 1'b0;
               tree_in = '0;  done_in = 1'b0;
            end
         end
         ST_SCAN: begin
            // Consume previous read; first read is entry [0][1] itself.
            if (pend_ff) begin
               if (!found_ff || rd_data < best_ff) begin
                  best_in = rd_data;  k_in = pi_ff;  l_in = pj_ff;
               end
               found_in = 1'b1;
            end
            if (!done_ff) begin
               rd_en = 1'b1;  rd_addr = {i_ff, j_ff};  pend_in = 1'b1;
               if (j_ff == n_last) begin
                  if (i_ff + VB'(1) == n_last) begin
                     done_in = 1'b1;
                  end else begin
                     i_in = i_ff + VB'(1);  j_in = i_ff + VB'(2);
                  end
               end else begin
                  j_in = j_ff + VB'(1);
               end
            end else if (!pend_ff) begin
               state_in = ST_FEMIT;
            end
         end
         ST_FEMIT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rsp_in.edge_from = k_ff;  rsp_in.edge_to = l_ff;
               rsp_in.edge_cost = best_ff;
               rsp_in.last_edge = n_last == VB'(1);
               tree_in[k_ff] = 1'b1;  tree_in[l_ff] = 1'b1;
               state_in = ST_INIT;  i_in = '0;  ph_in = 1'b0;  done_in = 1'b0;
            end
         end
         ST_INIT: begin
            // Per vertex: read [i][k] then [i][l], choose nearest.
            if (pend_ff) begin
               if (!pph_ff) begin
                  tmp_in = rd_data;
               end else begin
                  nw_en = 1'b1;  nw_addr = pi_ff;
                  nw_data = (tmp_ff < rd_data) ? k_ff : l_ff;
               end
            end
            if (!done_ff) begin
               rd_en = 1'b1;  pend_in = 1'b1;
               rd_addr = {i_ff, ph_ff ? l_ff : k_ff};
               ph_in = !ph_ff;
               if (ph_ff) begin
                  if (i_ff == n_last) done_in = 1'b1;
                  else i_in = i_ff + VB'(1);
               end
            end else if (!pend_ff) begin
               if (n_last == VB'(1)) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_SRCH;  step_in = VB'(1);  ph_in = 1'b0;
                  i_in = '0;  done_in = 1'b0;  found_in = 1'b0;
               end
            end
         end
         ST_SRCH: begin
            // Per non-tree vertex: fetch its nearest link, then read that cost.
            if (pend_ff) begin
               if (!found_ff || rd_data < best_ff) begin
                  best_in = rd_data;  u_in = pi_ff;  un_in = pn_ff;
               end
               found_in = 1'b1;
            end
            if (!done_ff) begin
               if (tree_ff[i_ff]) begin
                  if (i_ff == n_last) done_in = 1'b1;
                  else i_in = i_ff + VB'(1);
               end else if (!ph_ff) begin
                  ph_in = 1'b1;
               end else begin
                  rd_en = 1'b1;  pend_in = 1'b1;  rd_addr = {i_ff, near_q};
                  pn_in = near_q;  ph_in = 1'b0;
                  if (i_ff == n_last) done_in = 1'b1;
                  else i_in = i_ff + VB'(1);
               end
            end else if (!pend_ff) begin
               state_in = ST_SEMIT;
            end
         end
         ST_SEMIT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rsp_in.edge_from = u_ff;  rsp_in.edge_to = un_ff;
               rsp_in.edge_cost = best_ff;
               rsp_in.last_edge = step_ff + VB'(1) == n_last;
               tree_in[u_ff] = 1'b1;
               if (step_ff + VB'(1) == n_last) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_UPD;  i_in = '0;  ph_in = 1'b0;  done_in = 1'b0;
               end
            end
         end
         ST_UPD: begin
            // Per non-tree vertex: read [i][u], then the current link cost.
            if (pend_ff && pph_ff) begin
               if (rd_data > tmp_ff) begin
                  nw_en = 1'b1;  nw_addr = pi_ff;  nw_data = u_ff;
               end
            end else if (pend_ff) begin
               tmp_in = rd_data;
            end
            if (!done_ff) begin
               if (tree_ff[i_ff]) begin
                  if (i_ff == n_last) done_in = 1'b1;
                  else i_in = i_ff + VB'(1);
               end else begin
                  rd_en = 1'b1;  pend_in = 1'b1;
                  rd_addr = {i_ff, ph_ff ? near_q : u_ff};
                  ph_in = !ph_ff;
                  if (ph_ff) begin
                     if (i_ff == n_last) done_in = 1'b1;
                     else i_in = i_ff + VB'(1);
                  end
               end
            end else if (!pend_ff) begin
               state_in = ST_SRCH;  step_in = step_ff + VB'(1);  ph_in = 1'b0;
               i_in = '0;  done_in = 1'b0;  found_in = 1'b0;
            end
         end
         ST_FIN: begin
            // Wait until the last edge has been taken.
            if (!rv_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         done_ff  <= 1'b0;
         found_ff <= 1'b0;
         ph_ff    <= 1'b0;
         tree_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
         done_ff  <= done_in;
         found_ff <= found_in;
         ph_ff    <= ph_in;
         tree_ff  <= tree_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      i_ff <= i_in;  j_ff <= j_in;  pi_ff <= pi_in;  pj_ff <= pj_in;
      pn_ff <= pn_in;  un_ff <= un_in;
      pph_ff <= pph_in;  best_ff <= best_in;  tmp_ff <= tmp_in;
      k_ff <= k_in;  l_ff <= l_in;  u_ff <= u_in;  step_ff <= step_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Spanning tree unit testbench
// Loads cost matrices and runs tree searches, and checks every emitted edge
// against a local model of the nearest-vertex search, while both ports
// idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 200000;
   localparam int DirectedRows  = 22;

   typedef enum logic {ROW_CONFIG, ROW_REQUEST} row_kind_type;

   typedef struct {
      row_kind_type      kind;
      logic [6:0]        count;
      pmst_pkg::req_type req;
      bit                typed;
      pmst_pkg::rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   pmst_pkg::req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   pmst_pkg::rsp_type rsp_payload;
   logic    csr_write;
   logic [6:0] csr_data;

   // Local copy of the block's state.
   logic [15:0] cost_matrix [pmst_pkg::MaxVertices][pmst_pkg::MaxVertices];
   bit          entry_written [pmst_pkg::MaxVertices][pmst_pkg::MaxVertices];
   logic [6:0]  vertex_count_reg;
   pmst_pkg::rsp_type pending_edges [$];

   int  mismatches = 0;
   int  items_sent;
   int  send_idle_pct;
   int  stall_pct;
   int  hold_requests = 0;
   int  idle_cycles = 0;

   stim_row_type directed_rows [DirectedRows] = '{
      '{ROW_CONFIG,  7'd0, '{pmst_pkg::OP_WRITE, 6'd0, 6'd0, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd0, 6'd0, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd0, 6'd1, 16'hFFFF}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd1, 6'd0, 16'hFFFF}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd1, 6'd1, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_RUN, 6'd0, 6'd0, 16'h0000}, 1,
        '{6'd0, 6'd1, 16'hFFFF, 1'b1}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd0, 6'd1, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd1, 6'd0, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_RUN, 6'd0, 6'd0, 16'h0000}, 1,
        '{6'd0, 6'd1, 16'h0000, 1'b1}},
      '{ROW_CONFIG,  7'd3, '{pmst_pkg::OP_WRITE, 6'd0, 6'd0, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd0, 6'd2, 16'h0005}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd2, 6'd0, 16'h0005}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd1, 6'd2, 16'h0007}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd2, 6'd1, 16'h0007}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd2, 6'd2, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_RUN, 6'd21, 6'd42, 16'h5A5A}, 0, '{0, 0, 0, 0}},
      '{ROW_CONFIG,  7'd1, '{pmst_pkg::OP_WRITE, 6'd0, 6'd0, 16'h0000}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_RUN, 6'd0, 6'd0, 16'h0000}, 1,
        '{6'd0, 6'd1, 16'h0000, 1'b1}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd63, 6'd63, 16'hFFFF}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_WRITE, 6'd63, 6'd0, 16'h0001}, 0, '{0, 0, 0, 0}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_RUN, 6'd63, 6'd63, 16'hFFFF}, 1,
        '{6'd0, 6'd1, 16'h0000, 1'b1}},
      '{ROW_REQUEST, 7'd0, '{pmst_pkg::OP_RUN, 6'd0, 6'd0, 16'h0000}, 0, '{0, 0, 0, 0}}
   };

   prim_minimum_spanning_tree_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_data    (csr_data)
   );

   // Clock with a 20 ns period.
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Works out the tree edges of one run from the local state.
   function automatic void predict_spanning_tree();
      int          n;
      int          k;
      int          l;
      int          u;
      bit          found;
      logic [15:0] best;
      logic [15:0] c;
      int          nearest [pmst_pkg::MaxVertices];
      bit          joined [pmst_pkg::MaxVertices];
      pmst_pkg::rsp_type edge_item;
      n = (vertex_count_reg < 2) ? 2 : (vertex_count_reg > pmst_pkg::MaxVertices) ?
          pmst_pkg::MaxVertices : int'(vertex_count_reg);
      k = 0;
      l = 1;
      best = cost_matrix[0][1];
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if (cost_matrix[i][j] < best) begin
               best = cost_matrix[i][j];
               k = i;
               l = j;
            end
         end
      end
      edge_item = '{k[5:0], l[5:0], cost_matrix[k][l], n == 2};
      pending_edges.push_back(edge_item);
      for (int i = 0; i < n; i++) begin
         nearest[i] = (cost_matrix[i][k] < cost_matrix[i][l]) ? k : l;
         joined[i] = 1'b0;
      end
      joined[k] = 1'b1;
      joined[l] = 1'b1;
      for (int step = 1; step + 1 < n; step++) begin
         found = 1'b0;
         u = 0;
         best = '0;
         // Strictly cheapest nearest link, lowest index on ties.
         for (int i = 0; i < n; i++) begin
            if (!joined[i]) begin
               c = cost_matrix[i][nearest[i]];
               if (!found || c < best) begin
                  found = 1'b1;
                  best = c;
                  u = i;
               end
            end
         end
         edge_item = '{u[5:0], nearest[u][5:0], cost_matrix[u][nearest[u]],
                       step + 2 == n};
         pending_edges.push_back(edge_item);
         joined[u] = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (!joined[i] && cost_matrix[i][nearest[i]] > cost_matrix[i][u])
               nearest[i] = u;
         end
      end
   endfunction

   // Offers one request, waits for its acceptance and updates the model.
   task automatic send_request(input pmst_pkg::req_type r, input bit typed,
                               input pmst_pkg::rsp_type want);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (r.operation == pmst_pkg::OP_WRITE) begin
         cost_matrix[r.row_vertex][r.column_vertex]   = r.entry_weight;
         entry_written[r.row_vertex][r.column_vertex] = 1'b1;
      end else if (typed) begin
         pending_edges.push_back(want);
      end else begin
         predict_spanning_tree();
      end
   endtask

   task automatic send_write(input int row, input int col, input logic [15:0] w);
      send_request('{pmst_pkg::OP_WRITE, row[5:0], col[5:0], w}, 1'b0, '0);
   endtask

   task automatic send_run();
      send_request('{pmst_pkg::OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom)},
                   1'b0, '0);
   endtask

   // Stops offering and waits until every expected edge has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_edges.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The register is only written once the block has gone idle.
   task automatic set_vertex_count(input logic [6:0] value);
      wait_drained();
      csr_write <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      vertex_count_reg = value;
   endtask

   function automatic logic [15:0] random_weight();
      case ($urandom_range(3))
         0: return 16'($urandom_range(3));
         1: return ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Writes every entry of the used corner that is still unwritten, mirrored.
   task automatic fill_matrix(input int n);
      logic [15:0] w;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            if (!entry_written[i][j]) begin
               w = random_weight();
               send_write(i, j, w);
               if (!entry_written[j][i]) send_write(j, i, w);
            end
         end
      end
   endtask

   // One phase of random matrices and runs over small vertex counts.
   task automatic random_phase(input int idle_pct, input int stall, input int budget,
                               input bit do_hold, input bit do_pause);
      int          n;
      int          a;
      int          b;
      int          target;
      logic [15:0] w;
      target = items_sent + budget;
      send_idle_pct = idle_pct;
      stall_pct = stall;
      while (items_sent < target) begin
         case ($urandom_range(7))
            0: set_vertex_count(7'($urandom_range(1)));
            1: set_vertex_count(7'($urandom_range(2, 8)));
            default: if (vertex_count_reg > 8) set_vertex_count(7'd6);
         endcase
         n = (vertex_count_reg < 2) ? 2 : int'(vertex_count_reg);
         fill_matrix(n);
         // Rewrites: mostly mirrored pairs, some one-sided or outside the corner.
         repeat ($urandom_range(0, 6)) begin
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            w = random_weight();
            case ($urandom_range(5))
               0: send_write(a, b, w);
               1: send_write($urandom_range(63), $urandom_range(63), w);
               default: begin
                  send_write(a, b, w);
                  send_write(b, a, w);
               end
            endcase
         end
         if (do_hold) begin
            hold_requests++;
            do_hold = 1'b0;
            send_run();
            repeat (4) send_write(0, 1, cost_matrix[0][1]);
         end
         send_run();
         if (do_pause && $urandom_range(3) == 0) wait_drained();
      end
   endtask

   // Response side: random stalls and, on request, one long hold-off.
   initial begin
      int holds_served;
      holds_served = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Compares each taken edge with the oldest expected one.
   always @(posedge clock) begin
      pmst_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_edges.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected edge: from %0d to %0d cost %0d last %0d",
                        rsp_payload.edge_from, rsp_payload.edge_to,
                        rsp_payload.edge_cost, rsp_payload.last_edge);
         end else begin
            want = pending_edges.pop_front();
            if (rsp_payload.edge_from !== want.edge_from ||
                rsp_payload.edge_to !== want.edge_to ||
                rsp_payload.edge_cost !== want.edge_cost ||
                rsp_payload.last_edge !== want.last_edge) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Edge mismatch: expected %0d-%0d cost %0d last %0d,",
                           want.edge_from, want.edge_to, want.edge_cost,
                           want.last_edge, " got %0d-%0d cost %0d last %0d",
                           rsp_payload.edge_from, rsp_payload.edge_to,
                           rsp_payload.edge_cost, rsp_payload.last_edge);
            end
         end
      end
   end

   // Ends the run when nothing has been accepted for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write = 1'b0;
      csr_data = '0;
      items_sent = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      vertex_count_reg = 7'd64;
      for (int i = 0; i < pmst_pkg::MaxVertices; i++)
         for (int j = 0; j < pmst_pkg::MaxVertices; j++)
            entry_written[i][j] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: extremes, ties and saturated counts.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CONFIG)
            set_vertex_count(directed_rows[r].count);
         else
            send_request(directed_rows[r].req, directed_rows[r].typed,
                         directed_rows[r].want);
      end

      // Random phases with different idling on both sides.
      random_phase(0, 0, 90, 1'b0, 1'b0);
      random_phase(58, 0, 80, 1'b1, 1'b0);
      random_phase(0, 58, 80, 1'b0, 1'b1);
      random_phase(11, 11, 80, 1'b0, 1'b1);

      // One closing run over a wider corner with a zero-cost pair.
      set_vertex_count(7'd10);
      send_idle_pct = 0;
      stall_pct = 11;
      fill_matrix(10);
      send_write(5, 9, 16'd0);
      send_write(9, 5, 16'd0);
      send_run();

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_edges.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/pmst_pkg.sv
hw/rtl/prim_minimum_spanning_tree_unit.sv
verif/testbench.sv
